>>> src/stwa_pkg.sv
// ----------------------------------------------------------------------------
// stwa_pkg: shared types and constants
// Widths of the stage timings, the running sums, the window indexes and the
// sequencer states of the stage time window averager.
// ----------------------------------------------------------------------------
`default_nettype none

package stwa_pkg;

  localparam int WINDOW    = 64;
  localparam int STAGES    = 4;
  localparam int TIME_W    = 24;
  localparam int SLOT_W    = $clog2(WINDOW);
  localparam int FILL_W    = $clog2(WINDOW + 1);
  localparam int SUM_W     = TIME_W + SLOT_W;
  localparam int DIV_CNT_W = $clog2(SUM_W);
  localparam int STAGE_W   = $clog2(STAGES);
  localparam int CODE_W    = 3;
  localparam int TOTAL_W   = 32;

  localparam logic [CODE_W-1:0] STAGE_NONE = CODE_W'(STAGES);

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIVIDE,
    ST_RANK,
    ST_DONE
  } state_e;

  typedef logic [STAGES-1:0][TIME_W-1:0] times_t;
  typedef logic [STAGES-1:0][SUM_W-1:0]  sums_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

`default_nettype wire

>>> src/stwa_if.sv
// ----------------------------------------------------------------------------
// stwa channel interfaces
// Command channel (frame timings or clear) and result channel, each with a
// valid/ready handshake and its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface stwa_cmd_if;
  import stwa_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [TIME_W-1:0] decode_us;
  logic [TIME_W-1:0] upscale_us;
  logic [TIME_W-1:0] filter_us;
  logic [TIME_W-1:0] encode_us;

  modport source (
    output valid, command, decode_us, upscale_us, filter_us, encode_us,
    input  ready
  );

  modport sink (
    input  valid, command, decode_us, upscale_us, filter_us, encode_us,
    output ready
  );
endinterface

interface stwa_res_if;
  import stwa_pkg::*;

  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  mean_decode_us;
  logic [TIME_W-1:0]  mean_upscale_us;
  logic [TIME_W-1:0]  mean_filter_us;
  logic [TIME_W-1:0]  mean_encode_us;
  logic [CODE_W-1:0]  slowest_stage;
  logic [TOTAL_W-1:0] frames_seen;
  logic [FILL_W-1:0]  frames_held;

  modport source (
    output valid, mean_decode_us, mean_upscale_us, mean_filter_us,
           mean_encode_us, slowest_stage, frames_seen, frames_held,
    input  ready
  );

  modport sink (
    input  valid, mean_decode_us, mean_upscale_us, mean_filter_us,
           mean_encode_us, slowest_stage, frames_seen, frames_held,
    output ready
  );
endinterface

`default_nettype wire

>>> src/stwa_ring.sv
// ----------------------------------------------------------------------------
// stwa_ring: frame timing ring
// One-port-write, one-port-read memory of the last WINDOW frames, four
// timings per entry, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stwa_ring (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [stwa_pkg::SLOT_W-1:0] waddr_i,
  input  wire stwa_pkg::times_t      wdata_i,
  input  wire logic [stwa_pkg::SLOT_W-1:0] raddr_i,
  output stwa_pkg::times_t           rdata_o
);
  import stwa_pkg::*;

  times_t mem_q [WINDOW];
  times_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/stwa_div_lane.sv
// ----------------------------------------------------------------------------
// stwa_div_lane: bit-serial restoring divider
// Divides one running sum by the frame count, one quotient bit per cycle
// while ctrl_i.step is high, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module stwa_div_lane (
  input  wire logic                         clk_i,
  input  wire stwa_pkg::div_ctrl_t          ctrl_i,
  input  wire logic [stwa_pkg::SUM_W-1:0]   dividend_i,
  input  wire logic [stwa_pkg::FILL_W-1:0]  divisor_i,
  output logic [stwa_pkg::TIME_W-1:0]       quotient_o
);
  import stwa_pkg::*;

  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [FILL_W-1:0] rem_q, rem_d;
  logic [FILL_W:0]   trial;
  logic [FILL_W:0]   diff;
  logic              fits;

  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = trial >= {1'b0, divisor_i};
    quo_d = quo_q;
    rem_d = rem_q;
    if (ctrl_i.load) begin
      quo_d = dividend_i;
      rem_d = '0;
    end else if (ctrl_i.step) begin
      quo_d = {quo_q[SUM_W-2:0], fits};
      rem_d = fits ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quotient_o = quo_q[TIME_W-1:0];

endmodule

`default_nettype wire

>>> src/stage_time_window_averager.sv
// ----------------------------------------------------------------------------
// stage_time_window_averager: sliding-window stage timing statistics
// Keeps the last WINDOW frames of decode, upscale, filter and encode times,
// and reports per-stage truncated means, the slowest stage and frame counts.
//
// Channels: cmd_i takes one transaction per frame (command 0 records the
// four timings, command 1 clears all statistics); res_o returns exactly one
// result transaction for each command, in order.
// Sequence: a record fetches the evicted entry and updates the running sums
// (ST_FETCH), runs the four bit-serial dividers, one quotient bit per cycle
// (ST_DIVIDE), ranks the means (ST_RANK) and loads the result register
// (ST_DONE); a clear goes straight to ST_DONE. A new command is taken only
// after the current one is finished; cmd_i.ready is high only while idle.
// The result register frees the sequencer: the next command is accepted
// while a result still waits; a second finished result holds until res_o
// is taken.
// Reset: clears window, sums, counts and the result valid; ring contents
// stay undefined and are never used before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module stage_time_window_averager (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  stwa_cmd_if.sink    cmd_i,
  stwa_res_if.source  res_o
);
  import stwa_pkg::*;

  state_e state_q, state_d;

  logic                 cmd_acc;
  logic                 res_load;
  logic                 ring_we;
  div_ctrl_t            div_ctrl;

  times_t               time_q;
  times_t               ring_rdata;
  times_t               means;
  sums_t                sums_q, sums_d;
  logic [SLOT_W-1:0]    slot_q;
  logic [FILL_W-1:0]    fill_q;
  logic [TOTAL_W-1:0]   total_q;
  logic                 full;
  logic                 clr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [STAGE_W-1:0]   rank_q;
  logic [STAGE_W-1:0]   best_q;

  logic                 res_valid_q;
  times_t               res_means_q;
  logic [CODE_W-1:0]    res_slowest_q;
  logic [TOTAL_W-1:0]   res_seen_q;
  logic [FILL_W-1:0]    res_held_q;

  assign cmd_acc = cmd_i.valid && cmd_i.ready;
  assign full    = fill_q == FILL_W'(WINDOW);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_acc) begin
          state_d = (cmd_i.command == CMD_CLEAR) ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
          state_d = ST_RANK;
        end
      end
      ST_RANK: begin
        if (rank_q == STAGE_W'(STAGES - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid_q || res_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_i.ready   = 1'b0;
    ring_we       = 1'b0;
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    res_load      = 1'b0;
    case (state_q)
      ST_IDLE:   cmd_i.ready = 1'b1;
      ST_FETCH: begin
        ring_we       = 1'b1;
        div_ctrl.load = 1'b1;
      end
      ST_DIVIDE: div_ctrl.step = 1'b1;
      ST_RANK:   ;
      ST_DONE:   res_load = !res_valid_q || res_o.ready;
      default:   ;
    endcase
  end

  always_comb begin
    for (int s = 0; s < STAGES; s++) begin
      sums_d[s] = sums_q[s] + SUM_W'(time_q[s])
                  - (full ? SUM_W'(ring_rdata[s]) : SUM_W'(0));
    end
  end

  stwa_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (slot_q),
    .wdata_i (time_q),
    .raddr_i (slot_q),
    .rdata_o (ring_rdata)
  );

  for (genvar g = 0; g < STAGES; g++) begin : g_lane
    stwa_div_lane u_div (
      .clk_i      (clk_i),
      .ctrl_i     (div_ctrl),
      .dividend_i (sums_d[g]),
      .divisor_i  (fill_q),
      .quotient_o (means[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sums_q  <= '0;
      slot_q  <= '0;
      fill_q  <= '0;
      total_q <= '0;
      clr_q   <= 1'b0;
      cnt_q   <= '0;
      rank_q  <= '0;
      best_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (cmd_acc) begin
            clr_q <= cmd_i.command == CMD_CLEAR;
            if (cmd_i.command == CMD_CLEAR) begin
              sums_q  <= '0;
              slot_q  <= '0;
              fill_q  <= '0;
              total_q <= '0;
            end
          end
        end
        ST_FETCH: begin
          sums_q <= sums_d;
          slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
          if (!full) begin
            fill_q <= fill_q + FILL_W'(1);
          end
          if (total_q != '1) begin
            total_q <= total_q + TOTAL_W'(1);
          end
          cnt_q <= '0;
        end
        ST_DIVIDE: begin
          cnt_q  <= cnt_q + DIV_CNT_W'(1);
          best_q <= '0;
          rank_q <= STAGE_W'(1);
        end
        ST_RANK: begin
          if (means[rank_q] > means[best_q]) begin
            best_q <= rank_q;
          end
          rank_q <= rank_q + STAGE_W'(1);
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_acc) begin
      for (int s = 0; s < STAGES; s++) begin
        time_q[s] <= (s == 0) ? cmd_i.decode_us :
                     (s == 1) ? cmd_i.upscale_us :
                     (s == 2) ? cmd_i.filter_us : cmd_i.encode_us;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_means_q   <= clr_q ? '0 : means;
      res_slowest_q <= clr_q ? STAGE_NONE : CODE_W'(best_q);
      res_seen_q    <= total_q;
      res_held_q    <= fill_q;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.mean_decode_us  = res_means_q[0];
  assign res_o.mean_upscale_us = res_means_q[1];
  assign res_o.mean_filter_us  = res_means_q[2];
  assign res_o.mean_encode_us  = res_means_q[3];
  assign res_o.slowest_stage   = res_slowest_q;
  assign res_o.frames_seen     = res_seen_q;
  assign res_o.frames_held     = res_held_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WINDOW))
    else $error("fill count exceeds window");

  a_slot_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FILL_W'(WINDOW) |-> slot_q == fill_q[SLOT_W-1:0])
    else $error("write slot out of step with fill count");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && cmd_i.command == CMD_CLEAR |=> fill_q == '0 && total_q == '0)
    else $error("clear did not empty the window");

  a_record_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load && !clr_q |-> fill_q != '0 && total_q != '0)
    else $error("record result with empty window");

  a_rank_after_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RANK |-> $past(state_q) == ST_DIVIDE || $past(state_q) == ST_RANK)
    else $error("ranking entered without divide");

endmodule

`default_nettype wire
